[rtl/core/mcct_pkg.sv]
// ----------------------------------------------------------------------------
// mcct_pkg: shared definitions for the countdown timer bank
// Channel count, counter width, command codes and the control/status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mcct_pkg;

  // Bank size and counter width
  localparam int CHANNELS   = 16;
  localparam int COUNT_BITS = 32;
  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  // Width wide enough to compare a channel number against the bank size
  localparam int CH_CMP_W   = $clog2(CHANNELS + 1) + 4;

  // Field widths of the item ports
  localparam int MODE_W    = 2;
  localparam int CHANNEL_W = 4;
  localparam int PERIOD_W  = 32;

  // Item command codes
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2,
    MODE_QUERY = 2'd3
  } mode_t;

  // Result status codes
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_PARAM_ERR = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture the accepted item
    logic exec;       // run the captured item
    logic walk_step;  // process one channel of a tick walk
    logic finish;     // emit the closing result of a tick walk
  } mcct_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;   // result register can take a new result this cycle
    logic is_tick;    // captured item is a tick
    logic tick_en;    // tick enable register
    logic walk_last;  // walk is at the final channel
  } mcct_sts_t;

endpackage

[rtl/core/multi_channel_countdown_timer_core.sv]
// ----------------------------------------------------------------------------
// multi_channel_countdown_timer_core: bank of one-shot/periodic timers
// Top level joining the sequencing controller and the channel datapath.
// ----------------------------------------------------------------------------
// A start, stop or query item is captured on acceptance, then executed into
// the result register. An enabled tick walks the channel registers one channel
// per cycle and gives one result per expired channel in ascending order, or
// one empty result; a stall on the result side pauses the walk. One item is
// in work at a time; the next is accepted as soon as the previous one has
// placed its last result in the output register.
// ----------------------------------------------------------------------------
module multi_channel_countdown_timer_core import mcct_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [MODE_W-1:0]    in_mode,
  input  logic [CHANNEL_W-1:0] in_channel,
  input  logic [PERIOD_W-1:0]  in_period,
  input  logic                 in_periodic,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_status,
  output logic [CHANNEL_W-1:0] out_channel_out,
  output logic                 out_expired,
  output logic                 out_is_active,
  output logic                 out_last
);

  mcct_cmd_t cmd;
  mcct_sts_t sts;

  // Sequencing
  mcct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Channel state and results
  mcct_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_mode         (in_mode),
    .in_channel      (in_channel),
    .in_period       (in_period),
    .in_periodic     (in_periodic),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_channel_out (out_channel_out),
    .out_expired     (out_expired),
    .out_is_active   (out_is_active),
    .out_last        (out_last)
  );

endmodule

[rtl/core/mcct_ctrl.sv]
// ----------------------------------------------------------------------------
// mcct_ctrl: sequencing for the countdown timer bank
// Accepts one item at a time and steps the datapath through execution and,
// for an enabled tick, a walk over every channel followed by a closing result.
// ----------------------------------------------------------------------------
module mcct_ctrl import mcct_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  mcct_sts_t sts,
  output mcct_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;

  // Decode commands and next state
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = (sts.is_tick && sts.tick_en) ? ST_WALK : ST_IDLE;
        end
      end
      ST_WALK: begin
        if (sts.out_free) begin
          cmd.walk_step = 1'b1;
          if (sts.walk_last) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Only one command at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

  // A walk always ends with a closing result
  a_walk_to_finish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_step && sts.walk_last |=> state_r == ST_FINISH)
    else $error("walk did not move to its closing result");

  // Results only go out when the result register is free
  a_cmd_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec || cmd.walk_step || cmd.finish) |-> sts.out_free)
    else $error("command issued while the result register is blocked");

endmodule

[rtl/core/mcct_dp.sv]
// ----------------------------------------------------------------------------
// mcct_dp: channel state and result path of the countdown timer bank
// Holds per-channel flags, periods and counts, executes start, stop and
// query items, walks the channels on a tick and drives the result register.
// ----------------------------------------------------------------------------
module mcct_dp import mcct_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mcct_cmd_t            cmd,
  output mcct_sts_t            sts,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic [MODE_W-1:0]    in_mode,
  input  logic [CHANNEL_W-1:0] in_channel,
  input  logic [PERIOD_W-1:0]  in_period,
  input  logic                 in_periodic,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_status,
  output logic [CHANNEL_W-1:0] out_channel_out,
  output logic                 out_expired,
  output logic                 out_is_active,
  output logic                 out_last
);

  localparam logic [CH_CMP_W-1:0] CH_LIMIT = CH_CMP_W'(CHANNELS);
  localparam logic [CH_IDX_W-1:0] IDX_LAST = CH_IDX_W'(CHANNELS - 1);

  // Channel state
  logic [CHANNELS-1:0]   active_r;
  logic [CHANNELS-1:0]   periodic_r;
  logic [COUNT_BITS-1:0] period_r [CHANNELS];
  logic [COUNT_BITS-1:0] remain_r [CHANNELS];
  logic                  tick_en_r;

  // Captured item
  mode_t                 mode_r;
  logic [CHANNEL_W-1:0]  chan_r;
  logic [PERIOD_W-1:0]   period_in_r;
  logic                  periodic_in_r;

  // Walk state and the expiry held back until the next one is known
  logic [CH_IDX_W-1:0]   idx_r;
  logic                  pend_v_r;
  logic [CH_IDX_W-1:0]   pend_ch_r;
  logic                  pend_act_r;

  // Result register
  logic                  out_valid_r;
  logic                  out_status_r;
  logic [CHANNEL_W-1:0]  out_channel_r;
  logic                  out_expired_r;
  logic                  out_is_active_r;
  logic                  out_last_r;

  logic                  out_free;
  logic                  ch_ok;
  logic [CH_IDX_W-1:0]   ch_idx;
  logic [COUNT_BITS-1:0] walk_rem;
  logic [COUNT_BITS-1:0] walk_dec;
  logic                  walk_act;
  logic                  walk_hit;

  assign out_free = !out_valid_r || !out_stall;
  assign ch_ok    = ({{(CH_CMP_W-CHANNEL_W){1'b0}}, chan_r} < CH_LIMIT);
  assign ch_idx   = CH_IDX_W'(chan_r);

  // Count down the walked channel, stopping at zero
  assign walk_act = active_r[idx_r];
  assign walk_rem = remain_r[idx_r];
  assign walk_dec = (walk_rem != '0) ? (walk_rem - COUNT_BITS'(1)) : walk_rem;
  assign walk_hit = walk_act && (walk_dec == '0);

  assign sts.out_free  = out_free;
  assign sts.is_tick   = (mode_r == MODE_TICK);
  assign sts.tick_en   = tick_en_r;
  assign sts.walk_last = (idx_r == IDX_LAST);

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_en_r <= 1'b1;
    end else if (cfg_wr_en) begin
      tick_en_r <= cfg_wr_data;
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_TICK;
    end else if (cmd.load) begin
      mode_r <= mode_t'(in_mode);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      chan_r        <= in_channel;
      period_in_r   <= in_period;
      periodic_in_r <= in_periodic;
    end
  end

  // Flag updates: start, stop and expiry of a one-shot channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= '0;
      periodic_r <= '0;
    end else if (cmd.exec && ch_ok) begin
      if (mode_r == MODE_START && period_in_r != '0) begin
        active_r[ch_idx]   <= 1'b1;
        periodic_r[ch_idx] <= periodic_in_r;
      end else if (mode_r == MODE_STOP) begin
        active_r[ch_idx] <= 1'b0;
      end
    end else if (cmd.walk_step && walk_hit && !periodic_r[idx_r]) begin
      active_r[idx_r] <= 1'b0;
    end
  end

  // Period and count storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        period_r[i] <= '0;
        remain_r[i] <= '0;
      end
    end else if (cmd.exec && ch_ok && mode_r == MODE_START && period_in_r != '0) begin
      period_r[ch_idx] <= COUNT_BITS'(period_in_r);
      remain_r[ch_idx] <= COUNT_BITS'(period_in_r);
    end else if (cmd.walk_step && walk_act) begin
      remain_r[idx_r] <= (walk_hit && periodic_r[idx_r]) ? period_r[idx_r] : walk_dec;
    end
  end

  // Walk index and held-back expiry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      pend_v_r <= 1'b0;
    end else if (cmd.exec) begin
      idx_r    <= '0;
      pend_v_r <= 1'b0;
    end else if (cmd.walk_step) begin
      idx_r <= idx_r + CH_IDX_W'(1);
      if (walk_hit) begin
        pend_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_step && walk_hit) begin
      pend_ch_r  <= idx_r;
      pend_act_r <= periodic_r[idx_r];
    end
  end

  // Result register: load on a new result, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.exec && !(sts.is_tick && tick_en_r)) || cmd.finish
                 || (cmd.walk_step && walk_hit && pend_v_r)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_channel_r <= (mode_r == MODE_TICK) ? '0 : chan_r;
      out_expired_r <= 1'b0;
      out_last_r    <= 1'b1;
      case (mode_r)
        MODE_TICK: begin
          out_status_r    <= STATUS_OK;
          out_is_active_r <= 1'b0;
        end
        MODE_START: begin
          if (!ch_ok) begin
            out_status_r    <= STATUS_PARAM_ERR;
            out_is_active_r <= 1'b0;
          end else if (period_in_r == '0) begin
            out_status_r    <= STATUS_PARAM_ERR;
            out_is_active_r <= active_r[ch_idx];
          end else begin
            out_status_r    <= STATUS_OK;
            out_is_active_r <= 1'b1;
          end
        end
        MODE_STOP: begin
          out_status_r    <= ch_ok ? STATUS_OK : STATUS_PARAM_ERR;
          out_is_active_r <= 1'b0;
        end
        MODE_QUERY: begin
          out_status_r    <= STATUS_OK;
          out_is_active_r <= ch_ok && active_r[ch_idx];
        end
        default: begin
          out_status_r    <= STATUS_OK;
          out_is_active_r <= 1'b0;
        end
      endcase
    end else if (cmd.walk_step && walk_hit && pend_v_r) begin
      // Earlier expiry goes out now that a later one follows
      out_status_r    <= STATUS_OK;
      out_channel_r   <= CHANNEL_W'(pend_ch_r);
      out_expired_r   <= 1'b1;
      out_is_active_r <= pend_act_r;
      out_last_r      <= 1'b0;
    end else if (cmd.finish) begin
      out_status_r    <= STATUS_OK;
      out_channel_r   <= pend_v_r ? CHANNEL_W'(pend_ch_r) : '0;
      out_expired_r   <= pend_v_r;
      out_is_active_r <= pend_v_r && pend_act_r;
      out_last_r      <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_channel_out = out_channel_r;
  assign out_expired     = out_expired_r;
  assign out_is_active   = out_is_active_r;
  assign out_last        = out_last_r;

  // An expiry result never carries an error
  a_exp_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_expired_r |-> out_status_r == STATUS_OK)
    else $error("expiry result with error status");

  // A fresh walk starts with nothing held back
  a_walk_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> !pend_v_r && idx_r == '0)
    else $error("walk state not cleared on execution");

  // The final channel step wraps the walk index
  a_idx_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_step && idx_r == IDX_LAST |=> idx_r == CH_IDX_W'(CHANNELS % (1 << CH_IDX_W)))
    else $error("walk index did not wrap after the final channel");

endmodule
